### rtl/asu_pkg.sv
// Shared types, field widths, command codes and register defaults for the ADC unit converter.
package asu_pkg;

  // Field widths.
  localparam int SAMPLE_BITS   = 12;
  localparam int VALUE_BITS    = 17;
  localparam int GAIN_BITS     = 8;
  localparam int NF_BITS       = 4;
  localparam int CAL_BITS      = 12;
  localparam int CMD_BITS      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int QUOT_BITS     = 16;

  // Number of registered stages from the input transfer to the output register.
  localparam int NUM_STAGES = 5;
  // Stages that live inside the arithmetic and divider modules.
  localparam int MID_STAGES = 3;

  // All-ones 16-bit result used for every saturated reading.
  localparam logic [VALUE_BITS-1:0] SAT_VALUE = VALUE_BITS'(65535);

  // Conversion kinds.
  typedef enum logic [CMD_BITS-1:0] {
    CMD_CURRENT   = 3'd0,
    CMD_OUT_VOLT  = 3'd1,
    CMD_RAIL_VOLT = 3'd2,
    CMD_EXT_TEMP  = 3'd3,
    CMD_SUPPLY    = 3'd4,
    CMD_DIE_TEMP  = 3'd5
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CURRENT_GAIN       = 3'd0,
    CFG_OUTPUT_VOLTAGE_GAIN = 3'd1,
    CFG_RAIL_VOLTAGE_GAIN  = 3'd2,
    CFG_NOISE_FLOOR        = 3'd3,
    CFG_DIE_CAL_CODE       = 3'd4,
    CFG_DIE_CAL_MILLIVOLTS = 3'd5
  } cfg_idx_e;

  // Register reset values.
  localparam logic [GAIN_BITS-1:0] CURRENT_GAIN_RST        = 8'd68;
  localparam logic [GAIN_BITS-1:0] OUTPUT_VOLTAGE_GAIN_RST = 8'd16;
  localparam logic [GAIN_BITS-1:0] RAIL_VOLTAGE_GAIN_RST   = 8'd4;
  localparam logic [NF_BITS-1:0]   NOISE_FLOOR_RST         = 4'd2;
  localparam logic [CAL_BITS-1:0]  DIE_CAL_CODE_RST        = 12'd0;
  localparam logic [CAL_BITS-1:0]  DIE_CAL_MILLIVOLTS_RST  = 12'd2048;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Input item.
  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    sample_t             sample_latest;
    sample_t             sample_previous;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         saturated;
  } out_item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [GAIN_BITS-1:0] current_gain;
    logic [GAIN_BITS-1:0] output_voltage_gain;
    logic [GAIN_BITS-1:0] rail_voltage_gain;
    logic [NF_BITS-1:0]   noise_floor;
    logic [CAL_BITS-1:0]  die_cal_code;
    logic [CAL_BITS-1:0]  die_cal_millivolts;
  } cfg_t;

endpackage

### rtl/asu_arith.sv
// Three-stage datapath for gain scaling and both temperature conversions.
module asu_arith import asu_pkg::*; (
  input  logic                   clk_i,
  input  logic [MID_STAGES-1:0]  en_i,
  input  logic [CMD_BITS-1:0]    cmd_i,
  input  sample_t                avg_i,
  input  cfg_t                   cfg_i,
  output logic [CMD_BITS-1:0]    cmd_o,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic                   sat_o
);

  localparam int PRODUCT_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam int TEMP_N_BITS  = SAMPLE_BITS + 4;
  localparam int DIE_N_BITS   = SAMPLE_BITS + CAL_BITS;
  // |avg - 800| * 50 / 195 is computed as |avg - 800| * 10 / 39.
  localparam int TEMP_ZERO    = 800;
  localparam int TEMP_SCALE   = 10;
  // Reciprocal of 39 scaled by 2^22, rounded up; exact for 16-bit numerators.
  localparam int TEMP_SHIFT   = 22;
  localparam int TEMP_RECIP_BITS = 17;
  localparam logic [TEMP_RECIP_BITS-1:0] TEMP_RECIP = 17'd107547;
  localparam int TEMP_P_BITS  = TEMP_N_BITS + TEMP_RECIP_BITS;
  localparam int TEMP_Q_BITS  = TEMP_P_BITS - TEMP_SHIFT;
  // Division by 1508 is a shift by two, then the reciprocal of 377 scaled by 2^31.
  localparam int DIE_SHIFT    = 31;
  localparam int DIE_RECIP_BITS = 23;
  localparam logic [DIE_RECIP_BITS-1:0] DIE_RECIP = 23'd5696244;
  localparam int DIE_M_BITS   = DIE_N_BITS - 2;
  localparam int DIE_P_BITS   = DIE_M_BITS + DIE_RECIP_BITS;
  localparam int DIE_Q_BITS   = DIE_P_BITS - DIE_SHIFT;
  localparam logic [VALUE_BITS-1:0] DIE_BASE = VALUE_BITS'(900);

  // Stage 1: raw products.
  logic [CMD_BITS-1:0]     s1_cmd_q;
  logic [PRODUCT_BITS-1:0] s1_prod_q, s1_prod_d;
  logic [TEMP_N_BITS-1:0]  s1_tn_q, s1_tn_d;
  logic                    s1_tneg_q, s1_tneg_d;
  logic [DIE_N_BITS-1:0]   s1_dn_q, s1_dn_d;
  logic                    s1_dneg_q, s1_dneg_d;
  logic [GAIN_BITS-1:0]    gain_sel;
  logic [SAMPLE_BITS-1:0]  t_abs, d_abs;

  // Stage 2: clamped gain result and reciprocal products.
  logic [CMD_BITS-1:0]     s2_cmd_q;
  logic [QUOT_BITS-1:0]    s2_gain_q, s2_gain_d;
  logic                    s2_gsat_q, s2_gsat_d;
  logic [TEMP_P_BITS-1:0]  s2_tprod_q, s2_tprod_d;
  logic [DIE_P_BITS-1:0]   s2_dprod_q, s2_dprod_d;
  logic                    s2_tneg_q, s2_dneg_q;

  // Stage 3: signed value per kind.
  logic [CMD_BITS-1:0]     s3_cmd_q;
  logic [VALUE_BITS-1:0]   s3_value_q, s3_value_d;
  logic                    s3_sat_q, s3_sat_d;
  logic [VALUE_BITS-1:0]   t_ext, d_ext;

  // Pick the gain for the kind, and take magnitudes of the temperature offsets.
  always_comb begin
    case (cmd_i)
      CMD_CURRENT:   gain_sel = cfg_i.current_gain;
      CMD_OUT_VOLT:  gain_sel = cfg_i.output_voltage_gain;
      CMD_RAIL_VOLT: gain_sel = cfg_i.rail_voltage_gain;
      default:       gain_sel = '0;
    endcase
    s1_tneg_d = (avg_i < SAMPLE_BITS'(TEMP_ZERO));
    t_abs     = s1_tneg_d ? (SAMPLE_BITS'(TEMP_ZERO) - avg_i) : (avg_i - SAMPLE_BITS'(TEMP_ZERO));
    s1_dneg_d = (avg_i < cfg_i.die_cal_code);
    d_abs     = s1_dneg_d ? (cfg_i.die_cal_code - avg_i) : (avg_i - cfg_i.die_cal_code);
    s1_prod_d = PRODUCT_BITS'(avg_i) * PRODUCT_BITS'(gain_sel);
    s1_tn_d   = TEMP_N_BITS'(t_abs) * TEMP_N_BITS'(TEMP_SCALE);
    s1_dn_d   = DIE_N_BITS'(d_abs) * DIE_N_BITS'(cfg_i.die_cal_millivolts);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_cmd_q  <= cmd_i;
      s1_prod_q <= s1_prod_d;
      s1_tn_q   <= s1_tn_d;
      s1_tneg_q <= s1_tneg_d;
      s1_dn_q   <= s1_dn_d;
      s1_dneg_q <= s1_dneg_d;
    end
  end

  // Clamp the gain product and multiply the temperature numerators by the reciprocals.
  always_comb begin
    s2_gsat_d  = |s1_prod_q[PRODUCT_BITS-1:QUOT_BITS];
    s2_gain_d  = s2_gsat_d ? {QUOT_BITS{1'b1}} : s1_prod_q[QUOT_BITS-1:0];
    s2_tprod_d = TEMP_P_BITS'(s1_tn_q) * TEMP_P_BITS'(TEMP_RECIP);
    s2_dprod_d = DIE_P_BITS'(s1_dn_q[DIE_N_BITS-1:2]) * DIE_P_BITS'(DIE_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_gain_q  <= s2_gain_d;
      s2_gsat_q  <= s2_gsat_d;
      s2_tprod_q <= s2_tprod_d;
      s2_dprod_q <= s2_dprod_d;
      s2_tneg_q  <= s1_tneg_q;
      s2_dneg_q  <= s1_dneg_q;
    end
  end

  // Apply signs and the die offset; neither temperature can leave the 16-bit signed range.
  always_comb begin
    t_ext = VALUE_BITS'(s2_tprod_q[TEMP_P_BITS-1:TEMP_SHIFT]);
    d_ext = VALUE_BITS'(s2_dprod_q[DIE_P_BITS-1:DIE_SHIFT]);
    case (s2_cmd_q)
      CMD_CURRENT, CMD_OUT_VOLT, CMD_RAIL_VOLT: begin
        s3_value_d = VALUE_BITS'(s2_gain_q);
        s3_sat_d   = s2_gsat_q;
      end
      CMD_EXT_TEMP: begin
        s3_value_d = s2_tneg_q ? (VALUE_BITS'(0) - t_ext) : t_ext;
        s3_sat_d   = 1'b0;
      end
      CMD_DIE_TEMP: begin
        s3_value_d = s2_dneg_q ? (DIE_BASE + d_ext) : (DIE_BASE - d_ext);
        s3_sat_d   = 1'b0;
      end
      default: begin
        s3_value_d = '0;
        s3_sat_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_cmd_q   <= s2_cmd_q;
      s3_value_q <= s3_value_d;
      s3_sat_q   <= s3_sat_d;
    end
  end

  assign cmd_o   = s3_cmd_q;
  assign value_o = s3_value_q;
  assign sat_o   = s3_sat_q;

  // Quotient widths must cover the largest temperature magnitudes.
  if (TEMP_Q_BITS < 10 || DIE_Q_BITS < 14) begin : g_width_check
    $error("asu_arith: quotient width too narrow");
  end

endmodule

### rtl/asu_div.sv
// Pipelined restoring divider for 2^24 / average, four quotient bits per step.
module asu_div import asu_pkg::*; (
  input  logic                  clk_i,
  input  logic [MID_STAGES-1:0] en_i,
  input  sample_t               den_i,
  output logic [QUOT_BITS-1:0]  quot_o,
  output logic                  small_o
);

  localparam int BITS_PER_STEP = 4;
  // 2^24 >> 16: the part of the numerator above the quotient window.
  localparam int INIT_REM = 256;
  // Averages up to this value give a quotient above 16 bits (or divide by zero).
  localparam int SMALL_LIMIT = 256;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] rem;
    logic [QUOT_BITS-1:0]   quot;
  } div_state_t;

  // Four restoring steps; numerator bits below the window are all zero.
  function automatic div_state_t div_chunk(input div_state_t st, input sample_t den);
    div_state_t             res;
    logic [SAMPLE_BITS:0]   shifted;
    logic                   bit_q;
    res = st;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      shifted = {res.rem, 1'b0};
      bit_q   = (shifted >= {1'b0, den});
      if (bit_q) begin
        shifted = shifted - {1'b0, den};
      end
      res.rem  = shifted[SAMPLE_BITS-1:0];
      res.quot = {res.quot[QUOT_BITS-2:0], bit_q};
    end
    return res;
  endfunction

  div_state_t st1_q, st1_d, st2_q, st2_d, st3_q, st3_d, st_init, st_last;
  sample_t    den1_q, den2_q, den3_q;
  logic       small1_q, small2_q, small3_q;

  // Quotient bits per stage, most significant first.
  always_comb begin
    st_init.rem  = SAMPLE_BITS'(INIT_REM);
    st_init.quot = '0;
    st1_d   = div_chunk(st_init, den_i);
    st2_d   = div_chunk(st1_q, den1_q);
    st3_d   = div_chunk(st2_q, den2_q);
    st_last = div_chunk(st3_q, den3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      st1_q    <= st1_d;
      den1_q   <= den_i;
      small1_q <= (den_i <= SAMPLE_BITS'(SMALL_LIMIT));
    end
    if (en_i[1]) begin
      st2_q    <= st2_d;
      den2_q   <= den1_q;
      small2_q <= small1_q;
    end
    if (en_i[2]) begin
      st3_q    <= st3_d;
      den3_q   <= den2_q;
      small3_q <= small2_q;
    end
  end

  assign quot_o  = st_last.quot;
  assign small_o = small3_q;

endmodule

### rtl/adc_sample_to_units_core.sv
// Top level of the ADC sample to engineering units converter.
// Items pass in order through stage 0, stages 1 to 3 and the output register. Throughput: one
// item per cycle unless the output stalls; the supply divider resolves four quotient bits in
// each of its four stages, and the temperature scaling uses two registered multiplies in a row.
// Reset clears all stage valid bits and loads the register defaults; payload is not reset.
module adc_sample_to_units_core import asu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  cfg_t                    cfg_q;
  logic [NUM_STAGES-1:0]   vld_q, vld_d, rdy;
  logic [SAMPLE_BITS:0]    sum;
  sample_t                 raw_avg, avg;
  logic [CMD_BITS-1:0]     s0_cmd_q;
  sample_t                 s0_raw_q, s0_avg_q;
  logic [CMD_BITS-1:0]     ar_cmd;
  logic [VALUE_BITS-1:0]   ar_value;
  logic                    ar_sat;
  logic [QUOT_BITS-1:0]    div_quot;
  logic                    div_small;
  out_item_t               out_q, out_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_gain        <= CURRENT_GAIN_RST;
      cfg_q.output_voltage_gain <= OUTPUT_VOLTAGE_GAIN_RST;
      cfg_q.rail_voltage_gain   <= RAIL_VOLTAGE_GAIN_RST;
      cfg_q.noise_floor         <= NOISE_FLOOR_RST;
      cfg_q.die_cal_code        <= DIE_CAL_CODE_RST;
      cfg_q.die_cal_millivolts  <= DIE_CAL_MILLIVOLTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CURRENT_GAIN:        cfg_q.current_gain        <= cfg_wdata_i[GAIN_BITS-1:0];
        CFG_OUTPUT_VOLTAGE_GAIN: cfg_q.output_voltage_gain <= cfg_wdata_i[GAIN_BITS-1:0];
        CFG_RAIL_VOLTAGE_GAIN:   cfg_q.rail_voltage_gain   <= cfg_wdata_i[GAIN_BITS-1:0];
        CFG_NOISE_FLOOR:         cfg_q.noise_floor         <= cfg_wdata_i[NF_BITS-1:0];
        CFG_DIE_CAL_CODE:        cfg_q.die_cal_code        <= cfg_wdata_i[CAL_BITS-1:0];
        CFG_DIE_CAL_MILLIVOLTS:  cfg_q.die_cal_millivolts  <= cfg_wdata_i[CAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its item moves on in the same cycle.
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];

  // Stage 0: average of the two samples and the noise floor.
  always_comb begin
    sum     = {1'b0, in_i.sample_latest} + {1'b0, in_i.sample_previous};
    raw_avg = sum[SAMPLE_BITS:1];
    avg     = (raw_avg <= {{(SAMPLE_BITS-NF_BITS){1'b0}}, cfg_q.noise_floor}) ? '0 : raw_avg;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_cmd_q <= in_i.cmd;
      s0_raw_q <= raw_avg;
      s0_avg_q <= avg;
    end
  end

  // Stages 1 to 3: scaling datapath and supply divider side by side.
  asu_arith u_arith (
    .clk_i   (clk_i),
    .en_i    (rdy[MID_STAGES:1]),
    .cmd_i   (s0_cmd_q),
    .avg_i   (s0_avg_q),
    .cfg_i   (cfg_q),
    .cmd_o   (ar_cmd),
    .value_o (ar_value),
    .sat_o   (ar_sat)
  );

  asu_div u_div (
    .clk_i   (clk_i),
    .en_i    (rdy[MID_STAGES:1]),
    .den_i   (s0_raw_q),
    .quot_o  (div_quot),
    .small_o (div_small)
  );

  // Stage 4: last divider bits, supply clamp and the output register.
  always_comb begin
    if (ar_cmd == CMD_SUPPLY) begin
      if (div_small) begin
        out_d.value     = SAT_VALUE;
        out_d.saturated = 1'b1;
      end else begin
        out_d.value     = VALUE_BITS'(div_quot);
        out_d.saturated = 1'b0;
      end
    end else begin
      out_d.value     = ar_value;
      out_d.saturated = ar_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NUM_STAGES-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_o       = out_q;

  // An empty output register never blocks the input.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NUM_STAGES-1] |-> in_ready_o)
    else $error("input stalled with an empty output register");

  // A transfer in without a transfer out adds exactly one item to the pipeline.
  a_item_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !(out_valid_o && out_ready_i)) |=>
      ($countones(vld_q) == $past($countones(vld_q)) + 1))
    else $error("accepted item was not tracked by the pipeline");

  // A transfer out without a transfer in removes exactly one item.
  a_item_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !(in_valid_i && in_ready_o)) |=>
      ($countones(vld_q) == $past($countones(vld_q)) - 1))
    else $error("delivered item was not retired from the pipeline");

  // Only the unsigned kinds clamp, and they always clamp to the 16-bit maximum.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.saturated) |-> (out_o.value == SAT_VALUE))
    else $error("saturated result is not the 16-bit maximum");

endmodule

### tb/sv/tb_adc_sample_to_units_core.sv
// Self-checking testbench for the ADC sample to engineering units converter.
module tb_adc_sample_to_units_core;
  import asu_pkg::*;

  // Conversion codes that the block does not define; they must give a zero reading.
  localparam logic [CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

  // Conversion constants.
  localparam int TEMP_OFFSET_CODE = 800;
  localparam int TEMP_SCALE_NUM   = 50;
  localparam int TEMP_SCALE_DEN   = 195;
  localparam int unsigned SUPPLY_DIVIDEND = 32'd16777216;
  localparam int DIE_BASE_TENTHS  = 900;
  localparam int DIE_SLOPE_DIV    = 4095 * 3684 / 10000;
  localparam int U16_MAX          = 65535;
  localparam int S16_MAX          = 32767;
  localparam int S16_MIN          = -32768;

  localparam int MAX_REPORTED = 10;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  in_item_t                 in_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  out_item_t                out_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  // Shadow copy of the configuration registers.
  cfg_t      shadow_cfg;
  // Readings predicted for accepted samples, oldest first.
  out_item_t expected_readings[$];
  int        mismatch_count;
  // Random idling on both sides, and a long output hold-off on request.
  bit        gaps_on;
  int        hold_request;
  int        hold_left;

  adc_sample_to_units_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Predict the reading for one sample pair under the shadow configuration.
  function automatic out_item_t predict_reading(in_item_t item);
    int unsigned raw_avg;
    int unsigned avg;
    int unsigned gain;
    int unsigned product;
    int          result;
    logic        clamped;
    out_item_t   reading;
    raw_avg = (int'(item.sample_latest) + int'(item.sample_previous)) >> 1;
    avg     = (raw_avg <= int'(shadow_cfg.noise_floor)) ? 0 : raw_avg;
    result  = 0;
    clamped = 1'b0;
    case (item.cmd)
      CMD_CURRENT, CMD_OUT_VOLT, CMD_RAIL_VOLT: begin
        if (item.cmd == CMD_CURRENT) gain = 32'(shadow_cfg.current_gain);
        else if (item.cmd == CMD_OUT_VOLT) gain = 32'(shadow_cfg.output_voltage_gain);
        else gain = 32'(shadow_cfg.rail_voltage_gain);
        product = avg * gain;
        if (product > U16_MAX) begin
          result  = U16_MAX;
          clamped = 1'b1;
        end else begin
          result = int'(product);
        end
      end
      CMD_EXT_TEMP: begin
        result = (int'(avg) - TEMP_OFFSET_CODE) * TEMP_SCALE_NUM / TEMP_SCALE_DEN;
      end
      CMD_SUPPLY: begin
        // The supply reading divides the raw average; the noise floor does not apply.
        if (raw_avg == 0 || SUPPLY_DIVIDEND / raw_avg > U16_MAX) begin
          result  = U16_MAX;
          clamped = 1'b1;
        end else begin
          result = int'(SUPPLY_DIVIDEND / raw_avg);
        end
      end
      CMD_DIE_TEMP: begin
        result = DIE_BASE_TENTHS - ((int'(avg) - int'(shadow_cfg.die_cal_code))
                 * int'(shadow_cfg.die_cal_millivolts)) / DIE_SLOPE_DIV;
      end
      default: begin
        result = 0;
      end
    endcase
    // Temperatures are clamped to the signed 16-bit range.
    if (item.cmd == CMD_EXT_TEMP || item.cmd == CMD_DIE_TEMP) begin
      if (result > S16_MAX) begin
        result  = S16_MAX;
        clamped = 1'b1;
      end else if (result < S16_MIN) begin
        result  = S16_MIN;
        clamped = 1'b1;
      end
    end
    reading.value     = VALUE_BITS'(result);
    reading.saturated = clamped;
    return reading;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) $display("mismatch: %s", msg);
  endtask

  // Record each input transfer and check each output transfer against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    out_item_t due;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_readings.push_back(predict_reading(in_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          flag_error($sformatf("reading %0d/%0b with none expected",
                               out_o.value, out_o.saturated));
        end else begin
          due = expected_readings.pop_front();
          if (out_o.value !== due.value)
            flag_error($sformatf("value expected %0d got %0d", due.value, out_o.value));
          if (out_o.saturated !== due.saturated)
            flag_error($sformatf("saturated expected %0b got %0b",
                                 due.saturated, out_o.saturated));
        end
      end
    end
  end

  // Output side: random stalls, or a long hold-off counted here when one is requested.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= !(gaps_on && $urandom_range(99) < 33);
    end
  end

  // Offer one sample pair and wait for its transfer.
  task automatic send_reading(logic [CMD_BITS-1:0] cmd, sample_t latest, sample_t previous);
    in_item_t item;
    item.cmd             = cmd;
    item.sample_latest   = latest;
    item.sample_previous = previous;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and wait until every predicted reading has come out.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_CURRENT_GAIN:        shadow_cfg.current_gain        = data[GAIN_BITS-1:0];
      CFG_OUTPUT_VOLTAGE_GAIN: shadow_cfg.output_voltage_gain = data[GAIN_BITS-1:0];
      CFG_RAIL_VOLTAGE_GAIN:   shadow_cfg.rail_voltage_gain   = data[GAIN_BITS-1:0];
      CFG_NOISE_FLOOR:         shadow_cfg.noise_floor         = data[NF_BITS-1:0];
      CFG_DIE_CAL_CODE:        shadow_cfg.die_cal_code        = data[CAL_BITS-1:0];
      CFG_DIE_CAL_MILLIVOLTS:  shadow_cfg.die_cal_millivolts  = data[CAL_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reprogram every register once the block has gone idle.
  task automatic load_settings(logic [CFG_DATA_BITS-1:0] cur_gain, vout_gain, rail_gain,
                               floor_level, cal_code, cal_mv);
    drain_pipeline();
    write_register(CFG_CURRENT_GAIN, cur_gain);
    write_register(CFG_OUTPUT_VOLTAGE_GAIN, vout_gain);
    write_register(CFG_RAIL_VOLTAGE_GAIN, rail_gain);
    write_register(CFG_NOISE_FLOOR, floor_level);
    write_register(CFG_DIE_CAL_CODE, cal_code);
    write_register(CFG_DIE_CAL_MILLIVOLTS, cal_mv);
  endtask

  // Samples biased toward the noise floor and the supply saturation knee.
  function automatic sample_t random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) return sample_t'($urandom_range(20));
    if (pick < 30) return sample_t'($urandom_range(300, 220));
    return sample_t'($urandom_range(4095));
  endfunction

  function automatic logic [CMD_BITS-1:0] random_cmd();
    if ($urandom_range(99) < 90) return CMD_BITS'($urandom_range(5));
    return ($urandom_range(1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
  endfunction

  // Every conversion kind at its corner values under the reset configuration.
  task automatic test_reset_defaults();
    send_reading(CMD_CURRENT, 12'hFFF, 12'hFFF);
    send_reading(CMD_CURRENT, 12'd2, 12'd3);
    send_reading(CMD_CURRENT, 12'd3, 12'd4);
    send_reading(CMD_OUT_VOLT, 12'hFFF, 12'hFFF);
    send_reading(CMD_OUT_VOLT, 12'd0, 12'hFFF);
    send_reading(CMD_RAIL_VOLT, 12'hFFF, 12'hFFF);
    send_reading(CMD_RAIL_VOLT, 12'd0, 12'd0);
    send_reading(CMD_EXT_TEMP, 12'd0, 12'd0);
    send_reading(CMD_EXT_TEMP, 12'd800, 12'd801);
    send_reading(CMD_EXT_TEMP, 12'hFFF, 12'hFFF);
    send_reading(CMD_EXT_TEMP, 12'd2, 12'd2);
    send_reading(CMD_SUPPLY, 12'd0, 12'd0);
    send_reading(CMD_SUPPLY, 12'd1, 12'd1);
    send_reading(CMD_SUPPLY, 12'd256, 12'd256);
    send_reading(CMD_SUPPLY, 12'd257, 12'd257);
    send_reading(CMD_SUPPLY, 12'hFFF, 12'hFFF);
    send_reading(CMD_SUPPLY, 12'hFFF, 12'd0);
    send_reading(CMD_DIE_TEMP, 12'd0, 12'd0);
    send_reading(CMD_DIE_TEMP, 12'hFFF, 12'hFFF);
    send_reading(CMD_DIE_TEMP, 12'd2047, 12'd2048);
    send_reading(CMD_SPARE_6, 12'hFFF, 12'hFFF);
    send_reading(CMD_SPARE_7, 12'hABC, 12'h543);
  endtask

  // All registers at their maximum, at zero, and then back to the reset values.
  task automatic test_register_extremes();
    for (int setting = 0; setting < 3; setting++) begin
      if (setting == 0)
        load_settings(12'd255, 12'd255, 12'd255, 12'd15, 12'hFFF, 12'hFFF);
      else if (setting == 1)
        load_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      else
        load_settings(CFG_DATA_BITS'(CURRENT_GAIN_RST), CFG_DATA_BITS'(OUTPUT_VOLTAGE_GAIN_RST),
                      CFG_DATA_BITS'(RAIL_VOLTAGE_GAIN_RST), CFG_DATA_BITS'(NOISE_FLOOR_RST),
                      CFG_DATA_BITS'(DIE_CAL_CODE_RST), CFG_DATA_BITS'(DIE_CAL_MILLIVOLTS_RST));
      for (int code = 0; code < 8; code++) begin
        send_reading(CMD_BITS'(code), 12'hFFF, 12'hFFF);
        send_reading(CMD_BITS'(code), random_sample(), random_sample());
      end
      // Either side of the highest noise floor.
      send_reading(CMD_CURRENT, 12'd15, 12'd16);
      send_reading(CMD_CURRENT, 12'd16, 12'd17);
    end
  endtask

  // Random sample pairs over several random configurations.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      load_settings(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
                    CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
                    CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom));
      repeat (150) send_reading(random_cmd(), random_sample(), random_sample());
    end
  endtask

  // Hold the output off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_request = 80;
    repeat (60) send_reading(random_cmd(), random_sample(), random_sample());
    gaps_on = 1'b1;
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_steady_stream();
    gaps_on = 1'b0;
    repeat (80) send_reading(random_cmd(), random_sample(), random_sample());
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_i           = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    gaps_on        = 1'b1;
    hold_request   = 0;
    hold_left      = 0;
    mismatch_count = 0;
    shadow_cfg.current_gain        = CURRENT_GAIN_RST;
    shadow_cfg.output_voltage_gain = OUTPUT_VOLTAGE_GAIN_RST;
    shadow_cfg.rail_voltage_gain   = RAIL_VOLTAGE_GAIN_RST;
    shadow_cfg.noise_floor         = NOISE_FLOOR_RST;
    shadow_cfg.die_cal_code        = DIE_CAL_CODE_RST;
    shadow_cfg.die_cal_millivolts  = DIE_CAL_MILLIVOLTS_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();

    drain_pipeline();
    repeat (NUM_STAGES * 4) @(posedge clk_i);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("tb_adc_sample_to_units_core: clean");
    end else begin
      $display("tb_adc_sample_to_units_core: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("tb_adc_sample_to_units_core: errors");
    $finish;
  end

endmodule
